>>> hw/rtl/ssmv_pkg.sv
// ----------------------------------------------------------------------------
// ssmv_pkg: shared types and helpers of the sliced sparse matrix-vector product
// Beat layouts, operation codes, control records and the saturating add used
// by the lane accumulators and the lane merge.
// ----------------------------------------------------------------------------
package ssmv_pkg;

  // Default configuration
  localparam int LANES_DEF       = 4;
  localparam int MAX_COLUMNS_DEF = 4096;
  localparam int MAX_ROWS_DEF    = 4096;

  // Lanes carried by one input beat
  localparam int IN_LANES = 4;

  // Field widths
  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int COL_W  = 12;
  localparam int ROW_W  = 12;
  localparam int LIVE_W = 3;
  localparam int ACC_W  = 64;
  localparam int Y_W    = 48;
  localparam int FRAC_SHIFT = 16;

  // Sorted row position, wide enough for the largest row store plus one
  localparam int POS_W = 17;

  // Result records buffered ahead of the emitter
  localparam int FIFO_DEPTH = 8;

  typedef enum logic [OP_W-1:0] {
    OP_START    = 3'd0,
    OP_LOAD_X   = 3'd1,
    OP_LOAD_MAP = 3'd2,
    OP_CROSS    = 3'd3,
    OP_IN_ROW   = 3'd4
  } ssmv_op_t;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] val_lane0;
    logic signed [VAL_W-1:0] val_lane1;
    logic signed [VAL_W-1:0] val_lane2;
    logic signed [VAL_W-1:0] val_lane3;
    logic [COL_W-1:0]        col_lane0;
    logic [COL_W-1:0]        col_lane1;
    logic [COL_W-1:0]        col_lane2;
    logic [COL_W-1:0]        col_lane3;
    logic                    block_end;
    logic [LIVE_W-1:0]       live_rows;
  } ssmv_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]      row;
    logic signed [Y_W-1:0] y_value;
    logic                  last;
  } ssmv_out_t;

  // Per-lane accumulator control
  typedef struct packed {
    logic clr;   // zero the accumulator
    logic acc;   // add this beat's product
    logic fin;   // block end: snapshot the sum and zero the accumulator
  } ssmv_lane_ctl_t;

  // One event headed for the emitter: a row map write or a finished block
  typedef struct packed {
    logic              mapw;
    logic              in_row;
    logic [LIVE_W-1:0] count;
    logic [POS_W-1:0]  base;
    logic [COL_W-1:0]  map_pos;
    logic [ROW_W-1:0]  map_raw;
  } ssmv_ctl_t;

  // Add two accumulator values, clamping at the signed limits
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
      s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

>>> hw/rtl/ssmv_ram.sv
// ----------------------------------------------------------------------------
// ssmv_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/ssmv_lane.sv
// ----------------------------------------------------------------------------
// ssmv_lane: one multiply-accumulate lane
// Holds a private copy of the x vector, multiplies the lane value by x at the
// lane column and keeps a saturating Q32.32 running sum. Block end snapshots.
// ----------------------------------------------------------------------------
module ssmv_lane #(
  parameter int MAX_COLUMNS = ssmv_pkg::MAX_COLUMNS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // x load, same on every lane
  input  logic                                   xw_en,
  input  logic [$clog2(MAX_COLUMNS)-1:0]         xw_addr,
  input  logic [ssmv_pkg::VAL_W-1:0]             xw_data,
  // lane operand at accept
  input  logic                                   rd_en,
  input  logic [$clog2(MAX_COLUMNS)-1:0]         rd_addr,
  input  logic                                   col_ok,
  input  logic signed [ssmv_pkg::VAL_W-1:0]      val,
  input  ssmv_pkg::ssmv_lane_ctl_t               ctl,
  // finished lane sum, valid the cycle after a block end leaves stage C
  output logic signed [ssmv_pkg::ACC_W-1:0]      snap
);

  logic [ssmv_pkg::VAL_W-1:0]        x_q;
  logic signed [ssmv_pkg::VAL_W-1:0] val_b_r;
  logic                              ok_b_r;
  ssmv_pkg::ssmv_lane_ctl_t          ctl_b_r;
  ssmv_pkg::ssmv_lane_ctl_t          ctl_c_r;
  logic signed [ssmv_pkg::VAL_W-1:0] x_sel;
  logic signed [ssmv_pkg::ACC_W-1:0] prod_nxt;
  logic signed [ssmv_pkg::ACC_W-1:0] prod_c_r;
  logic signed [ssmv_pkg::ACC_W-1:0] sum_c;
  logic signed [ssmv_pkg::ACC_W-1:0] acc_r;
  logic signed [ssmv_pkg::ACC_W-1:0] acc_nxt;
  logic signed [ssmv_pkg::ACC_W-1:0] snap_r;

  ssmv_ram #(
    .WIDTH (ssmv_pkg::VAL_W),
    .DEPTH (MAX_COLUMNS)
  ) u_x_ram (
    .clk     (clk),
    .wr_en   (xw_en),
    .wr_addr (xw_addr),
    .wr_data (xw_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (x_q)
  );

  // Stage B: operand registers alongside the x read
  always_ff @(posedge clk) begin
    val_b_r <= val;
    ok_b_r  <= col_ok;
  end

  // Stage B to C control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
      ctl_c_r <= '0;
    end else begin
      ctl_b_r <= ctl;
      ctl_c_r <= ctl_b_r;
    end
  end

  // Multiply; a column beyond the store reads as zero
  assign x_sel    = ok_b_r ? $signed(x_q) : '0;
  assign prod_nxt = val_b_r * x_sel;

  always_ff @(posedge clk) begin
    prod_c_r <= prod_nxt;
  end

  // Stage C: saturating accumulate
  assign sum_c = ssmv_pkg::sat_add(acc_r, prod_c_r);

  always_comb begin
    acc_nxt = acc_r;
    priority if (ctl_c_r.clr) begin
      acc_nxt = '0;
    end else if (ctl_c_r.acc) begin
      acc_nxt = ctl_c_r.fin ? '0 : sum_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // Capture the finished row sum
  always_ff @(posedge clk) begin
    if (ctl_c_r.acc && ctl_c_r.fin) begin
      snap_r <= sum_c;
    end
  end

  assign snap = snap_r;

endmodule

>>> hw/rtl/ssmv_merge.sv
// ----------------------------------------------------------------------------
// ssmv_merge: lane merge pipeline
// Adds the lane sums in lane order, one saturating add per stage, for in-row
// blocks. Lane sums ride along for cross-row blocks and map writes pass by.
// ----------------------------------------------------------------------------
module ssmv_merge #(
  parameter int NL = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_v,
  input  ssmv_pkg::ssmv_ctl_t                in_ctl,
  input  logic signed [ssmv_pkg::ACC_W-1:0]  snap [NL],
  output logic                               out_v,
  output ssmv_pkg::ssmv_ctl_t                out_ctl,
  output logic signed [ssmv_pkg::ACC_W-1:0]  out_sums [NL],
  output logic [$clog2(NL)-1:0]              inflight
);

  localparam int NS = NL - 1;

  logic [NS-1:0]                     v_r;
  ssmv_pkg::ssmv_ctl_t               ctl_r  [NS];
  logic signed [ssmv_pkg::ACC_W-1:0] part_r [NS];
  logic signed [ssmv_pkg::ACC_W-1:0] sums_r [NS][NL];

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int j = 0; j < NS; j++) begin
        v_r[j] <= (j == 0) ? in_v : v_r[(j == 0) ? 0 : j-1];
      end
    end
  end

  // Stage payload: stage j folds in lane j+1
  always_ff @(posedge clk) begin
    for (int j = 0; j < NS; j++) begin
      if (j == 0) begin
        ctl_r[j]  <= in_ctl;
        part_r[j] <= ssmv_pkg::sat_add(snap[0], snap[1]);
        sums_r[j] <= snap;
      end else begin
        ctl_r[j]  <= ctl_r[j-1];
        part_r[j] <= ssmv_pkg::sat_add(part_r[j-1], sums_r[j-1][j+1]);
        sums_r[j] <= sums_r[j-1];
      end
    end
  end

  // In-row blocks report the merged total in lane 0
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      out_sums[i] = sums_r[NS-1][i];
    end
    if (ctl_r[NS-1].in_row) begin
      out_sums[0] = part_r[NS-1];
    end
  end

  assign out_v    = v_r[NS-1];
  assign out_ctl  = ctl_r[NS-1];
  assign inflight = ($clog2(NL))'($countones(v_r));

endmodule

>>> hw/rtl/ssmv_emit.sv
// ----------------------------------------------------------------------------
// ssmv_emit: event queue, row map and result output
// Queues finished blocks and row map writes in order, applies map writes, then
// emits one result per cycle when out_ready allows, via read and output registers.
// ----------------------------------------------------------------------------
module ssmv_emit #(
  parameter int NL       = 4,
  parameter int MAX_ROWS = ssmv_pkg::MAX_ROWS_DEF,
  parameter int DEPTH    = ssmv_pkg::FIFO_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  ssmv_pkg::ssmv_ctl_t                push_ctl,
  input  logic signed [ssmv_pkg::ACC_W-1:0]  push_sums [NL],
  output logic [$clog2(DEPTH+1)-1:0]         fill,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ssmv_pkg::ssmv_out_t                out_data
);

  localparam int PW   = $clog2(DEPTH);
  localparam int FW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(NL);
  localparam int RA_W = $clog2(MAX_ROWS);
  localparam int SH   = ssmv_pkg::FRAC_SHIFT;

  ssmv_pkg::ssmv_ctl_t               ctl_q  [DEPTH];
  logic signed [ssmv_pkg::ACC_W-1:0] sums_q [DEPTH][NL];
  logic [PW-1:0]                     wr_ptr_r;
  logic [PW-1:0]                     rd_ptr_r;
  logic [FW-1:0]                     cnt_r;
  logic [IW-1:0]                     idx_r;

  ssmv_pkg::ssmv_ctl_t               hctl;
  logic signed [ssmv_pkg::ACC_W-1:0] hsum;
  logic                              head_v;
  logic                              last_i;
  logic [ssmv_pkg::POS_W:0]          pos;
  logic                              pos_ok;
  logic                              map_do;
  logic                              map_ok;
  logic                              rd_do;
  logic                              pop;
  logic                              move_o;
  logic                              issue_ok;
  logic [ssmv_pkg::ROW_W-1:0]        row_q;

  logic                              r_v_r;
  logic signed [ssmv_pkg::Y_W-1:0]   r_y_r;
  logic                              r_last_r;
  logic                              r_zero_r;
  logic                              o_v_r;
  ssmv_pkg::ssmv_out_t               o_data_r;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ctl_q[wr_ptr_r]  <= push_ctl;
      sums_q[wr_ptr_r] <= push_sums;
    end
  end

  // Head of queue
  assign head_v = (cnt_r != '0);
  assign hctl   = ctl_q[rd_ptr_r];
  assign hsum   = sums_q[rd_ptr_r][idx_r];
  assign last_i = ((4)'(idx_r) + 4'd1) == (4)'(hctl.count);
  assign pos    = {1'b0, hctl.base} + (ssmv_pkg::POS_W+1)'(idx_r);
  assign pos_ok = (32'(pos) < 32'(MAX_ROWS));
  assign map_ok = (32'(hctl.map_pos) < 32'(MAX_ROWS));

  // Flow: read stage frees when it moves into the output register
  assign move_o   = r_v_r & (~o_v_r | out_ready);
  assign issue_ok = ~r_v_r | move_o;
  assign map_do   = head_v & hctl.mapw;
  assign rd_do    = head_v & ~hctl.mapw & issue_ok;
  assign pop      = map_do | (rd_do & last_i);

  ssmv_ram #(
    .WIDTH (ssmv_pkg::ROW_W),
    .DEPTH (MAX_ROWS)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (map_do & map_ok),
    .wr_addr (RA_W'(32'(hctl.map_pos))),
    .wr_data (hctl.map_raw),
    .rd_en   (rd_do),
    .rd_addr (RA_W'(32'(pos))),
    .rd_data (row_q)
  );

  // Queue pointers, fill count and result index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      idx_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + FW'(push) - FW'(pop);
      if (rd_do) begin
        idx_r <= last_i ? '0 : idx_r + 1'b1;
      end
    end
  end

  // Read stage and output register valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      r_v_r <= rd_do | (r_v_r & ~move_o);
      o_v_r <= move_o | (o_v_r & ~out_ready);
    end
  end

  // Read stage payload: Q32.32 to Q32.16 by dropping the low fraction bits
  always_ff @(posedge clk) begin
    if (rd_do) begin
      r_y_r    <= hsum[ssmv_pkg::ACC_W-1:SH];
      r_last_r <= last_i;
      r_zero_r <= ~pos_ok;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (move_o) begin
      o_data_r.row     <= r_zero_r ? '0 : row_q;
      o_data_r.y_value <= r_y_r;
      o_data_r.last    <= r_last_r;
    end
  end

  assign fill      = cnt_r;
  assign out_valid = o_v_r;
  assign out_data  = o_data_r;

endmodule

>>> hw/rtl/sliced_sparse_matrix_vector_product_top.sv
// ----------------------------------------------------------------------------
// sliced_sparse_matrix_vector_product_top: sliced sparse matrix-vector product
// Four-lane sliced packing: lanes multiply matrix values by x and accumulate,
// block ends emit per-row sums (cross-row) or one merged sum (in-row).
// ----------------------------------------------------------------------------
//
//  port group | dir | handshake           | beat
//  -----------+-----+---------------------+-------------------------------
//  in_        | in  | in_valid/in_ready   | ssmv_in_t: op, 4 values, 4 cols
//  out_       | out | out_valid/out_ready | ssmv_out_t: row, y_value, last
//
//  One input beat a cycle while in_ready is high; one MAC per lane per beat.
//  A result passes through stages B to D, the lane merge, the event queue,
//  the read stage and the output register. Results leave one per cycle
//  while out_ready is high; a cross-row block end gives one per live row.
//  in_ready drops when the 8-entry event queue plus beats in flight is full.
//  Reset is synchronous; stores are not cleared and are undefined until loaded.
//
module sliced_sparse_matrix_vector_product_top #(
  parameter int LANES       = ssmv_pkg::LANES_DEF,
  parameter int MAX_COLUMNS = ssmv_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = ssmv_pkg::MAX_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssmv_pkg::ssmv_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ssmv_pkg::ssmv_out_t out_data
);

  localparam int NL   = (LANES < ssmv_pkg::IN_LANES) ? LANES : ssmv_pkg::IN_LANES;
  localparam int XA_W = $clog2(MAX_COLUMNS);
  localparam int RC_W = $clog2(MAX_ROWS + 1);
  localparam int RS_W = RC_W + 1;
  localparam int MC_W = $clog2(NL);
  localparam int FC_W = $clog2(ssmv_pkg::FIFO_DEPTH + 1);
  localparam int CR_W = $clog2(ssmv_pkg::FIFO_DEPTH + NL + 4);

  logic                              fire;
  logic                              is_start;
  logic                              is_ldx;
  logic                              is_ldm;
  logic                              is_cross;
  logic                              is_inrow;
  logic                              fin_a;
  logic [ssmv_pkg::LIVE_W-1:0]       n_cross;
  logic [ssmv_pkg::LIVE_W-1:0]       n_adv;
  logic [RS_W-1:0]                   cnt_sum;
  logic [RC_W-1:0]                   cnt_adv;
  logic [RC_W-1:0]                   cnt_r;
  logic [RC_W-1:0]                   cnt_nxt;

  logic signed [ssmv_pkg::VAL_W-1:0] val_a  [ssmv_pkg::IN_LANES];
  logic [ssmv_pkg::COL_W-1:0]        col_a  [ssmv_pkg::IN_LANES];
  logic [ssmv_pkg::IN_LANES-1:0]     col_ok;

  ssmv_pkg::ssmv_lane_ctl_t          lane_ctl;
  ssmv_pkg::ssmv_ctl_t               ctl_a;
  logic                              pend_a;
  ssmv_pkg::ssmv_ctl_t               ctl_b_r;
  ssmv_pkg::ssmv_ctl_t               ctl_c_r;
  ssmv_pkg::ssmv_ctl_t               ctl_d_r;
  logic                              pend_b_r;
  logic                              pend_c_r;
  logic                              pend_d_r;

  logic signed [ssmv_pkg::ACC_W-1:0] snap     [NL];
  logic signed [ssmv_pkg::ACC_W-1:0] m_sums   [NL];
  ssmv_pkg::ssmv_ctl_t               m_ctl;
  logic                              m_v;
  logic [MC_W-1:0]                   m_inflight;
  logic [FC_W-1:0]                   q_fill;
  logic [CR_W-1:0]                   credit_used;

  // Lane operands from the beat
  assign val_a[0] = in_data.val_lane0;
  assign val_a[1] = in_data.val_lane1;
  assign val_a[2] = in_data.val_lane2;
  assign val_a[3] = in_data.val_lane3;
  assign col_a[0] = in_data.col_lane0;
  assign col_a[1] = in_data.col_lane1;
  assign col_a[2] = in_data.col_lane2;
  assign col_a[3] = in_data.col_lane3;

  always_comb begin
    for (int i = 0; i < ssmv_pkg::IN_LANES; i++) begin
      col_ok[i] = (32'(col_a[i]) < 32'(MAX_COLUMNS));
    end
  end

  assign fire = in_valid & in_ready;

  // Decode the operation; unused codes do nothing
  always_comb begin
    is_start = 1'b0;
    is_ldx   = 1'b0;
    is_ldm   = 1'b0;
    is_cross = 1'b0;
    is_inrow = 1'b0;
    unique case (in_data.operation)
      ssmv_pkg::OP_START:    is_start = 1'b1;
      ssmv_pkg::OP_LOAD_X:   is_ldx   = 1'b1;
      ssmv_pkg::OP_LOAD_MAP: is_ldm   = 1'b1;
      ssmv_pkg::OP_CROSS:    is_cross = 1'b1;
      ssmv_pkg::OP_IN_ROW:   is_inrow = 1'b1;
      default: ;
    endcase
  end

  assign fin_a   = (is_cross | is_inrow) & in_data.block_end;
  assign n_cross = (in_data.live_rows > ssmv_pkg::LIVE_W'(NL))
                   ? ssmv_pkg::LIVE_W'(NL) : in_data.live_rows;
  assign n_adv   = is_cross ? n_cross : ssmv_pkg::LIVE_W'(1);

  // Sorted row counter, tracked in beat order at accept
  assign cnt_sum = RS_W'(cnt_r) + RS_W'(n_adv);
  assign cnt_adv = (cnt_sum > RS_W'(MAX_ROWS)) ? RC_W'(MAX_ROWS) : cnt_sum[RC_W-1:0];

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (fire && is_start) begin
      cnt_nxt = '0;
    end else if (fire && fin_a) begin
      cnt_nxt = cnt_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Lane control, qualified by accept
  assign lane_ctl.clr = fire & is_start;
  assign lane_ctl.acc = fire & (is_cross | is_inrow);
  assign lane_ctl.fin = fire & fin_a;

  // Event control for the emitter
  assign ctl_a.mapw    = is_ldm;
  assign ctl_a.in_row  = is_inrow;
  assign ctl_a.count   = is_inrow ? ssmv_pkg::LIVE_W'(1) : n_cross;
  assign ctl_a.base    = ssmv_pkg::POS_W'(cnt_r);
  assign ctl_a.map_pos = in_data.col_lane0;
  assign ctl_a.map_raw = in_data.col_lane1;
  assign pend_a = fire & (is_ldm | (fin_a & (is_inrow | (n_cross != '0))));

  // Lanes
  for (genvar g = 0; g < NL; g++) begin : g_lane
    ssmv_lane #(
      .MAX_COLUMNS (MAX_COLUMNS)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .xw_en   (fire & is_ldx & col_ok[0]),
      .xw_addr (XA_W'(32'(in_data.col_lane0))),
      .xw_data (in_data.val_lane0),
      .rd_en   (fire),
      .rd_addr (XA_W'(32'(col_a[g]))),
      .col_ok  (col_ok[g]),
      .val     (val_a[g]),
      .ctl     (lane_ctl),
      .snap    (snap[g])
    );
  end

  // Event pipeline in step with the lanes: B (x read), C (multiply), D (sum)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_b_r <= 1'b0;
      pend_c_r <= 1'b0;
      pend_d_r <= 1'b0;
    end else begin
      pend_b_r <= pend_a;
      pend_c_r <= pend_b_r;
      pend_d_r <= pend_c_r;
    end
  end

  always_ff @(posedge clk) begin
    ctl_b_r <= ctl_a;
    ctl_c_r <= ctl_b_r;
    ctl_d_r <= ctl_c_r;
  end

  ssmv_merge #(
    .NL (NL)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (pend_d_r),
    .in_ctl   (ctl_d_r),
    .snap     (snap),
    .out_v    (m_v),
    .out_ctl  (m_ctl),
    .out_sums (m_sums),
    .inflight (m_inflight)
  );

  ssmv_emit #(
    .NL       (NL),
    .MAX_ROWS (MAX_ROWS),
    .DEPTH    (ssmv_pkg::FIFO_DEPTH)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (m_v),
    .push_ctl  (m_ctl),
    .push_sums (m_sums),
    .fill      (q_fill),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Reserve a queue slot for every event still in flight
  assign credit_used = CR_W'(q_fill) + CR_W'(m_inflight) + CR_W'(pend_b_r)
                     + CR_W'(pend_c_r) + CR_W'(pend_d_r);
  assign in_ready    = (credit_used < CR_W'(ssmv_pkg::FIFO_DEPTH));

  // Queue slots reserved never exceed the queue
  a_credit_bound : assert property (@(posedge clk) disable iff (!rst_n)
    credit_used <= CR_W'(ssmv_pkg::FIFO_DEPTH))
    else $error("event queue overcommitted");

  // A cross-row block end with live rows always enters the event pipeline
  a_cross_end_pend : assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_cross && in_data.block_end && (in_data.live_rows != '0) |=> pend_b_r)
    else $error("cross-row block end dropped");

  // An x load never produces an event
  a_ldx_no_pend : assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_ldx |=> !pend_b_r)
    else $error("x load produced an event");

  // Sorted row counter stays within the row store
  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RC_W'(MAX_ROWS))
    else $error("sorted row counter overran");

endmodule
